[rtl/bva_pkg.sv]
// ----------------------------------------------------------------------------
// bva_pkg: shared definitions of the bordered Vandermonde alignment block
// Sizes, register indexes, status codes and the request bundle that the
// sequencer hands to the modular multiplier.
// ----------------------------------------------------------------------------
package bva_pkg;

	// Store and subset sizes.
	localparam int unsigned MAX_POINTS = 16;
	localparam int unsigned MAX_TUPLE  = 8;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned PROD_W     = 2 * WORD_W;
	localparam int unsigned STEP_W     = $clog2(PROD_W);
	localparam int unsigned PTR_W      = $clog2(MAX_POINTS);
	localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int unsigned IDX_W      = $clog2(MAX_TUPLE);
	localparam int unsigned TUP_W      = $clog2(MAX_TUPLE + 1);
	localparam int unsigned COL_W      = 3;
	localparam int unsigned ROW_W      = 3 * WORD_W;

	// Register reset values and field limits.
	localparam logic [WORD_W-1:0] RESET_MODULUS = 32'd2013265921;
	localparam logic [WORD_W-1:0] MIN_MODULUS   = 32'd3;
	localparam logic [COL_W-1:0]  RESET_COLUMNS = 3'd1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MODULUS = 2'd0;
	localparam logic [1:0] CFG_COLUMNS = 2'd1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FEW  = 2'd1;
	localparam logic [1:0] STATUS_MANY = 2'd2;

	// One request to the modular multiplier.
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} mul_req_t;

endpackage

[rtl/bva_ram.sv]
// ----------------------------------------------------------------------------
// bva_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bva_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/bva_modmul.sv]
// ----------------------------------------------------------------------------
// bva_modmul: multi-cycle modular multiplier
// Registers the full product on start, then reduces it modulo p one bit per
// cycle by shift and conditional subtract. The result is valid with done.
// ----------------------------------------------------------------------------
module bva_modmul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bva_pkg::mul_req_t             req,
	input  logic [bva_pkg::WORD_W-1:0]    modulus,
	output logic                          done,
	output logic [bva_pkg::WORD_W-1:0]    result
);
	import bva_pkg::*;

	logic [PROD_W-1:0] prod_q;
	logic [WORD_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;
	logic [WORD_W-1:0] rem_nx;

	// One reduction step: bring in the next product bit and fold back below p.
	always_comb begin
		shifted = {rem_q, prod_q[PROD_W-1]};
		diff    = shifted - {1'b0, modulus};
		rem_nx  = (shifted >= {1'b0, modulus}) ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
	end

	// Product register and the bit-serial reduction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			prod_q <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				prod_q <= {{WORD_W{1'b0}}, req.a} * {{WORD_W{1'b0}}, req.b};
				rem_q  <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				rem_q  <= rem_nx;
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = rem_q;

endmodule

[rtl/bordered_vandermonde_alignment.sv]
// ----------------------------------------------------------------------------
// bordered_vandermonde_alignment: alignment test over a prime field
// Points (x, y0, y1) arrive on the input channel, one transfer each, and are
// written into a 16-entry point RAM; a point arriving with the RAM full is
// dropped and the set is marked as overflowed. The transfer whose last_point
// is set closes the set. The block then sweeps the (k+1)-subsets in
// lexicographic order, forms both bordered Vandermonde residuals by Laplace
// expansion, checks them against the first nondegenerate subset, stops at a
// mismatch and, if aligned with some nonzero second residual, computes gamma
// with a Fermat inverse. One result transfer leaves on the output channel per
// closed set; all other points give none. Loading takes one point per cycle
// while idle. A closed set that is flagged (too few or too many points) skips
// the sweep and goes straight to its result. A sweep is bound by the modular
// multiplies, the multiplier being the one shared unit: per subset 3(k+1)
// reductions, (k+1)*k*(k-1)/2 difference products, 2(k+1) terms and up to 2
// check products, plus up to 64 multiplies for the inverse. No new point is
// taken during a sweep. The result sits in an output register, so loading of
// the next set goes on while it waits; a finished sweep holds until that register
// is free. Reset empties the set and loads modulus 2013265921 and k = 1; the RAM is not cleared.
// ----------------------------------------------------------------------------
module bordered_vandermonde_alignment (
	input  logic                          clk,
	input  logic                          arst_n,
	// Point input channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bva_pkg::WORD_W-1:0]    point_x,
	input  logic [bva_pkg::WORD_W-1:0]    value_first,
	input  logic [bva_pkg::WORD_W-1:0]    value_second,
	input  logic                          last_point,
	// Result output channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          aligned,
	output logic                          has_gamma,
	output logic [bva_pkg::WORD_W-1:0]    gamma,
	output logic [1:0]                    status,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [bva_pkg::WORD_W-1:0]    cfg_data
);
	import bva_pkg::*;

	typedef enum logic [26:0] {
		S_IDLE    = 27'd1 << 0,
		S_LD_RD   = 27'd1 << 1,
		S_LD_CAP  = 27'd1 << 2,
		S_LD_X    = 27'd1 << 3,
		S_LD_Y0   = 27'd1 << 4,
		S_LD_Y1   = 27'd1 << 5,
		S_VD_INIT = 27'd1 << 6,
		S_VD_STEP = 27'd1 << 7,
		S_VD_XI   = 27'd1 << 8,
		S_VD_DIFF = 27'd1 << 9,
		S_VD_MULR = 27'd1 << 10,
		S_TM      = 27'd1 << 11,
		S_T0      = 27'd1 << 12,
		S_T1      = 27'd1 << 13,
		S_CHECK   = 27'd1 << 14,
		S_CK1     = 27'd1 << 15,
		S_CK2     = 27'd1 << 16,
		S_ADV     = 27'd1 << 17,
		S_FIN     = 27'd1 << 18,
		S_PW_STEP = 27'd1 << 19,
		S_PW_R    = 27'd1 << 20,
		S_PW_SQ   = 27'd1 << 21,
		S_PW_B    = 27'd1 << 22,
		S_PW_END  = 27'd1 << 23,
		S_PW_G    = 27'd1 << 24,
		S_DONE    = 27'd1 << 25,
		S_MUL     = 27'd1 << 26
	} state_t;

	// Field helpers; both operands are already below p.
	function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] p);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, p}) begin
			s = s - {1'b0, p};
		end
		return s[WORD_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] mod_sub(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] p);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, p} - {1'b0, b};
		return (a >= b) ? (a - b) : s[WORD_W-1:0];
	endfunction

	state_t            state_q, ret_q;
	logic [WORD_W-1:0] modulus_q;
	logic [COL_W-1:0]  columns_q;
	logic [WORD_W-1:0] p_eff;

	logic [CNT_W-1:0]  cnt_q, n_q;
	logic              ovf_q;
	logic [TUP_W-1:0]  m_q;
	logic              kodd_q;
	logic [PTR_W-1:0]  c_q [MAX_TUPLE];
	logic [IDX_W-1:0]  t_q, a_q;
	logic [TUP_W-1:0]  i_q, j_q;
	logic [WORD_W-1:0] xs_q [MAX_TUPLE];
	logic [WORD_W-1:0] y0_q [MAX_TUPLE];
	logic [WORD_W-1:0] y1_q [MAX_TUPLE];
	logic [WORD_W-1:0] vd_q, xi_q, acc0_q, acc1_q;
	logic [WORD_W-1:0] ref0_q, ref1_q, g0_q, g1_q, prod0_q;
	logic              ref_seen_q, have_g_q;
	logic [WORD_W-1:0] base_q, pr_q, exp_q;

	logic              res_aligned_q, res_has_gamma_q;
	logic [WORD_W-1:0] res_gamma_q;
	logic [1:0]        res_status_q;
	logic              out_valid_q, out_aligned_q, out_has_gamma_q;
	logic [WORD_W-1:0] out_gamma_q;
	logic [1:0]        out_status_q;
	logic              out_load;

	mul_req_t          mul_q;
	logic              mul_done;
	logic [WORD_W-1:0] mul_res;

	logic              in_xfer, ram_we, store_ok;
	logic [ROW_W-1:0]  ram_rdata;
	logic [CNT_W-1:0]  cnt_nx;
	logic              ovf_nx;
	logic [TUP_W-1:0]  m_cfg;
	logic [WORD_W-1:0] xs_sel;
	logic [TUP_W-1:0]  a_ext;

	logic              enum_more;
	logic [IDX_W-1:0]  enum_sel;
	logic [PTR_W-1:0]  enum_val;
	logic [PTR_W-1:0]  c_nx [MAX_TUPLE];
	logic [CNT_W-1:0]  lim;

	// Effective modulus: anything below three counts as three.
	assign p_eff = (modulus_q < MIN_MODULUS) ? MIN_MODULUS : modulus_q;

	// Point loading.
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign store_ok  = (cnt_q < CNT_W'(MAX_POINTS));
	assign ram_we    = in_xfer && store_ok;
	assign cnt_nx    = store_ok ? (cnt_q + CNT_W'(1)) : cnt_q;
	assign ovf_nx    = ovf_q || !store_ok;
	assign m_cfg     = TUP_W'(columns_q) + TUP_W'(1);
	assign a_ext     = TUP_W'(a_q);

	// A finished set moves to the output register once that register is free.
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// One read address into the subset value registers.
	assign xs_sel = (state_q == S_VD_XI) ? xs_q[i_q[IDX_W-1:0]] : xs_q[j_q[IDX_W-1:0]];

	// Next subset in lexicographic order: the rightmost index below its limit.
	always_comb begin
		enum_more = 1'b0;
		enum_sel  = '0;
		enum_val  = '0;
		lim       = '0;
		for (int l = 0; l < MAX_TUPLE; l++) begin
			lim = n_q - CNT_W'(m_q) + CNT_W'(l);
			if ((TUP_W'(l) < m_q) && ({1'b0, c_q[l]} != lim)) begin
				enum_more = 1'b1;
				enum_sel  = IDX_W'(l);
				enum_val  = c_q[l];
			end
		end
		for (int l = 0; l < MAX_TUPLE; l++) begin
			if (IDX_W'(l) < enum_sel) begin
				c_nx[l] = c_q[l];
			end else begin
				c_nx[l] = enum_val + PTR_W'(l) - PTR_W'(enum_sel) + PTR_W'(1);
			end
		end
	end

	// Point store: x, y0 and y1 side by side in one row.
	bva_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_POINTS)
	) u_points (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[PTR_W-1:0]),
		.wdata ({point_x, value_first, value_second}),
		.raddr (c_q[t_q]),
		.rdata (ram_rdata)
	);

	// Shared modular multiplier.
	bva_modmul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_q),
		.modulus (p_eff),
		.done    (mul_done),
		.result  (mul_res)
	);

	// Configuration, sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			ret_q           <= S_IDLE;
			modulus_q       <= RESET_MODULUS;
			columns_q       <= RESET_COLUMNS;
			cnt_q           <= '0;
			n_q             <= '0;
			ovf_q           <= 1'b0;
			m_q             <= '0;
			kodd_q          <= 1'b0;
			t_q             <= '0;
			a_q             <= '0;
			i_q             <= '0;
			j_q             <= '0;
			vd_q            <= '0;
			xi_q            <= '0;
			acc0_q          <= '0;
			acc1_q          <= '0;
			ref0_q          <= '0;
			ref1_q          <= '0;
			g0_q            <= '0;
			g1_q            <= '0;
			prod0_q         <= '0;
			ref_seen_q      <= 1'b0;
			have_g_q        <= 1'b0;
			base_q          <= '0;
			pr_q            <= '0;
			exp_q           <= '0;
			res_aligned_q   <= 1'b0;
			res_has_gamma_q <= 1'b0;
			res_gamma_q     <= '0;
			res_status_q    <= STATUS_OK;
			out_valid_q     <= 1'b0;
			out_aligned_q   <= 1'b0;
			out_has_gamma_q <= 1'b0;
			out_gamma_q     <= '0;
			out_status_q    <= STATUS_OK;
			mul_q           <= '0;
			for (int l = 0; l < MAX_TUPLE; l++) begin
				c_q[l]  <= '0;
				xs_q[l] <= '0;
				y0_q[l] <= '0;
				y1_q[l] <= '0;
			end
		end else begin
			// Register writes.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MODULUS) begin
					modulus_q <= cfg_data;
				end else if (cfg_index == CFG_COLUMNS) begin
					columns_q <= cfg_data[COL_W-1:0];
				end
			end

			// The output register fills with a finished set and empties on a transfer.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (last_point) begin
							cnt_q           <= '0;
							ovf_q           <= 1'b0;
							res_aligned_q   <= 1'b0;
							res_has_gamma_q <= 1'b0;
							res_gamma_q     <= '0;
							n_q             <= cnt_nx;
							m_q             <= m_cfg;
							kodd_q          <= columns_q[0];
							t_q             <= '0;
							ref_seen_q      <= 1'b0;
							have_g_q        <= 1'b0;
							for (int l = 0; l < MAX_TUPLE; l++) begin
								c_q[l] <= PTR_W'(l);
							end
							if (ovf_nx) begin
								res_status_q <= STATUS_MANY;
								state_q      <= S_DONE;
							end else if (cnt_nx < CNT_W'(m_cfg)) begin
								res_status_q <= STATUS_FEW;
								state_q      <= S_DONE;
							end else begin
								res_status_q <= STATUS_OK;
								state_q      <= S_LD_RD;
							end
						end else begin
							cnt_q <= cnt_nx;
							ovf_q <= ovf_nx;
						end
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_CAP;
				end
				S_LD_CAP: begin
					mul_q   <= '{start: 1'b1, a: ram_rdata[3*WORD_W-1:2*WORD_W], b: 32'd1};
					ret_q   <= S_LD_X;
					state_q <= S_MUL;
				end
				S_LD_X: begin
					xs_q[t_q] <= mul_res;
					mul_q     <= '{start: 1'b1, a: ram_rdata[2*WORD_W-1:WORD_W], b: 32'd1};
					ret_q     <= S_LD_Y0;
					state_q   <= S_MUL;
				end
				S_LD_Y0: begin
					y0_q[t_q] <= mul_res;
					mul_q     <= '{start: 1'b1, a: ram_rdata[WORD_W-1:0], b: 32'd1};
					ret_q     <= S_LD_Y1;
					state_q   <= S_MUL;
				end
				S_LD_Y1: begin
					y1_q[t_q] <= mul_res;
					if (TUP_W'(t_q) == m_q - TUP_W'(1)) begin
						a_q     <= '0;
						acc0_q  <= '0;
						acc1_q  <= '0;
						state_q <= S_VD_INIT;
					end else begin
						t_q     <= t_q + IDX_W'(1);
						state_q <= S_LD_RD;
					end
				end
				S_VD_INIT: begin
					vd_q    <= 32'd1;
					i_q     <= '0;
					j_q     <= TUP_W'(1);
					state_q <= S_VD_STEP;
				end
				// Walk the pairs i < j of the minor that leaves out row a.
				S_VD_STEP: begin
					priority if (i_q + TUP_W'(1) >= m_q) begin
						state_q <= S_TM;
					end else if ((j_q >= m_q) || (i_q == a_ext)) begin
						i_q <= i_q + TUP_W'(1);
						j_q <= i_q + TUP_W'(2);
					end else if (j_q == a_ext) begin
						j_q <= j_q + TUP_W'(1);
					end else begin
						state_q <= S_VD_XI;
					end
				end
				S_VD_XI: begin
					xi_q    <= xs_sel;
					state_q <= S_VD_DIFF;
				end
				S_VD_DIFF: begin
					mul_q   <= '{start: 1'b1, a: vd_q, b: mod_sub(xs_sel, xi_q, p_eff)};
					ret_q   <= S_VD_MULR;
					state_q <= S_MUL;
				end
				S_VD_MULR: begin
					vd_q    <= mul_res;
					j_q     <= j_q + TUP_W'(1);
					state_q <= S_VD_STEP;
				end
				S_TM: begin
					mul_q   <= '{start: 1'b1, a: y0_q[a_q], b: vd_q};
					ret_q   <= S_T0;
					state_q <= S_MUL;
				end
				S_T0: begin
					acc0_q  <= (a_q[0] ^ kodd_q) ? mod_sub(acc0_q, mul_res, p_eff)
					                             : mod_add(acc0_q, mul_res, p_eff);
					mul_q   <= '{start: 1'b1, a: y1_q[a_q], b: vd_q};
					ret_q   <= S_T1;
					state_q <= S_MUL;
				end
				S_T1: begin
					acc1_q <= (a_q[0] ^ kodd_q) ? mod_sub(acc1_q, mul_res, p_eff)
					                            : mod_add(acc1_q, mul_res, p_eff);
					if (a_ext == m_q - TUP_W'(1)) begin
						state_q <= S_CHECK;
					end else begin
						a_q     <= a_q + IDX_W'(1);
						state_q <= S_VD_INIT;
					end
				end
				// Compare against the reference subset by cross-multiplication.
				S_CHECK: begin
					if (ref_seen_q) begin
						mul_q   <= '{start: 1'b1, a: acc0_q, b: ref1_q};
						ret_q   <= S_CK1;
						state_q <= S_MUL;
					end else begin
						if ((acc0_q != '0) || (acc1_q != '0)) begin
							ref0_q     <= acc0_q;
							ref1_q     <= acc1_q;
							ref_seen_q <= 1'b1;
						end
						state_q <= S_ADV;
					end
				end
				S_CK1: begin
					prod0_q <= mul_res;
					mul_q   <= '{start: 1'b1, a: ref0_q, b: acc1_q};
					ret_q   <= S_CK2;
					state_q <= S_MUL;
				end
				S_CK2: begin
					if (prod0_q != mul_res) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if ((acc1_q != '0) && !have_g_q) begin
						g0_q     <= acc0_q;
						g1_q     <= acc1_q;
						have_g_q <= 1'b1;
					end
					if (enum_more) begin
						for (int l = 0; l < MAX_TUPLE; l++) begin
							c_q[l] <= c_nx[l];
						end
						t_q     <= '0;
						state_q <= S_LD_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!ref_seen_q) begin
						state_q <= S_DONE;
					end else if (!have_g_q) begin
						res_aligned_q <= 1'b1;
						state_q       <= S_DONE;
					end else begin
						base_q  <= g1_q;
						pr_q    <= 32'd1;
						exp_q   <= p_eff - 32'd2;
						state_q <= S_PW_STEP;
					end
				end
				// Fermat inverse by square and multiply, low exponent bit first.
				S_PW_STEP: begin
					priority if (exp_q == '0) begin
						state_q <= S_PW_END;
					end else if (exp_q[0]) begin
						mul_q   <= '{start: 1'b1, a: pr_q, b: base_q};
						ret_q   <= S_PW_R;
						state_q <= S_MUL;
					end else begin
						state_q <= S_PW_SQ;
					end
				end
				S_PW_R: begin
					pr_q    <= mul_res;
					state_q <= S_PW_SQ;
				end
				S_PW_SQ: begin
					mul_q   <= '{start: 1'b1, a: base_q, b: base_q};
					ret_q   <= S_PW_B;
					state_q <= S_MUL;
				end
				S_PW_B: begin
					base_q  <= mul_res;
					exp_q   <= {1'b0, exp_q[WORD_W-1:1]};
					state_q <= S_PW_STEP;
				end
				S_PW_END: begin
					mul_q   <= '{start: 1'b1, a: mod_sub('0, g0_q, p_eff), b: pr_q};
					ret_q   <= S_PW_G;
					state_q <= S_MUL;
				end
				S_PW_G: begin
					res_gamma_q     <= mul_res;
					res_aligned_q   <= 1'b1;
					res_has_gamma_q <= 1'b1;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_aligned_q   <= res_aligned_q;
						out_has_gamma_q <= res_has_gamma_q;
						out_gamma_q     <= res_gamma_q;
						out_status_q    <= res_status_q;
						state_q         <= S_IDLE;
					end
				end
				// The start pulse lasts one cycle; then wait for the product.
				S_MUL: begin
					mul_q.start <= 1'b0;
					if (mul_done) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign aligned   = out_aligned_q;
	assign has_gamma = out_has_gamma_q;
	assign gamma     = out_gamma_q;
	assign status    = out_status_q;

`ifndef SYNTHESIS
	// The multiplier only finishes while the sequencer waits for it.
	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL))
		else $error("multiplier finished outside its wait state");

	// The fill count never passes the store depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	// A flagged set never reports alignment.
	a_flag_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != STATUS_OK)) |-> (!out_aligned_q && !out_has_gamma_q))
		else $error("flagged set reported as aligned");

	// Gamma is only given for an aligned set.
	a_gamma_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_has_gamma_q) |-> out_aligned_q)
		else $error("gamma without alignment");

	// A finished set reaches the output register once it is free.
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && !out_valid_q) |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("finished result not loaded");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bordered_vandermonde_alignment
// Point sets are built as aligned sets with a known gamma, aligned sets
// without a second residual, degenerate sets and noise. The sets are sent
// under several modulus and column settings. A predictor in the bench
// computes the expected result of every closed set, and a monitor compares
// each result transfer with the oldest expected one. Both channels stall at
// random, and the receiver once holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top;
	import bva_pkg::*;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y0;
		logic [31:0] y1;
		logic        last;
	} point_t;

	typedef struct {
		logic        aligned;
		logic        has_gamma;
		logic [31:0] gamma;
		logic [1:0]  status;
	} verdict_t;

	localparam int STALL_LIMIT = 600000;
	localparam int LONG_HOLD   = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] point_x = '0;
	logic [31:0] value_first = '0;
	logic [31:0] value_second = '0;
	logic        last_point = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        aligned;
	logic        has_gamma;
	logic [31:0] gamma;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_MODULUS;
	logic [31:0] cfg_data = '0;

	bordered_vandermonde_alignment u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state: the point store and the register copies.
	logic [31:0] pt_x[MAX_POINTS];
	logic [31:0] pt_y0[MAX_POINTS];
	logic [31:0] pt_y1[MAX_POINTS];
	int unsigned pt_count;
	bit          pt_dropped;
	logic [31:0] reg_modulus = RESET_MODULUS;
	logic [2:0]  reg_columns = RESET_COLUMNS;
	longint unsigned fp;

	point_t   point_q[$];
	verdict_t verdict_q[$];
	int       mismatches;
	int       results_seen;
	bit       no_idle;
	int       watchdog;

	function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
		return 32'(({32'b0, a} * {32'b0, b}) % fp);
	endfunction

	function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
		longint unsigned t;
		t = longint'(a) + longint'(b);
		return 32'(t >= fp ? t - fp : t);
	endfunction

	function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
		return a >= b ? a - b : 32'(longint'(a) + fp - longint'(b));
	endfunction

	function automatic logic [31:0] fpow(logic [31:0] a, longint unsigned e);
		logic [31:0] r;
		logic [31:0] b;
		r = 32'd1;
		b = 32'(a % fp);
		while (e != 0) begin
			if (e[0])
				r = fmul(r, b);
			b = fmul(b, b);
			e = e >> 1;
		end
		return r;
	endfunction

	// Laplace expansion of the bordered matrix along the value column.
	function automatic logic [31:0] bordered_residual(logic [31:0] xs[MAX_TUPLE],
			logic [31:0] ys[MAX_TUPLE], int k);
		logic [31:0] acc;
		logic [31:0] rest[MAX_TUPLE];
		logic [31:0] vd;
		logic [31:0] term;
		int c;
		acc = 0;
		for (int a = 0; a <= k; a++) begin
			c = 0;
			for (int b = 0; b <= k; b++)
				if (b != a) begin
					rest[c] = xs[b];
					c++;
				end
			vd = 32'd1;
			for (int i = 0; i < k; i++)
				for (int j = i + 1; j < k; j++)
					vd = fmul(vd, fsub(rest[j], rest[i]));
			term = fmul(ys[a], vd);
			acc = ((a + k) & 1) ? fsub(acc, term) : fadd(acc, term);
		end
		return acc;
	endfunction

	// Sweep of all (k+1)-subsets against the first nondegenerate one.
	function automatic verdict_t sweep_subsets(int n, int k);
		verdict_t v;
		int sel[MAX_TUPLE];
		int m;
		int i;
		logic [31:0] xs[MAX_TUPLE];
		logic [31:0] ya[MAX_TUPLE];
		logic [31:0] yb[MAX_TUPLE];
		logic [31:0] r0, r1, ref0, ref1, g0, g1;
		bit ref_seen, have_g;
		v = '{1'b0, 1'b0, 32'd0, STATUS_OK};
		m = k + 1;
		ref_seen = 0;
		have_g = 0;
		ref0 = 0; ref1 = 0; g0 = 0; g1 = 0;
		for (i = 0; i < m; i++)
			sel[i] = i;
		forever begin
			for (i = 0; i < m; i++) begin
				xs[i] = 32'(pt_x[sel[i]] % fp);
				ya[i] = 32'(pt_y0[sel[i]] % fp);
				yb[i] = 32'(pt_y1[sel[i]] % fp);
			end
			r0 = bordered_residual(xs, ya, k);
			r1 = bordered_residual(xs, yb, k);
			if (ref_seen) begin
				if (fmul(r0, ref1) != fmul(ref0, r1))
					return v;
			end else if (r0 != 0 || r1 != 0) begin
				ref0 = r0;
				ref1 = r1;
				ref_seen = 1;
			end
			if (r1 != 0 && !have_g) begin
				g0 = r0;
				g1 = r1;
				have_g = 1;
			end
			i = m - 1;
			while (i >= 0 && sel[i] == n - m + i)
				i--;
			if (i < 0)
				break;
			sel[i]++;
			for (int j = i + 1; j < m; j++)
				sel[j] = sel[j - 1] + 1;
		end
		if (ref_seen) begin
			v.aligned = 1'b1;
			if (have_g) begin
				v.has_gamma = 1'b1;
				v.gamma = fmul(fsub(0, g0), fpow(g1, fp - 2));
			end
		end
		return v;
	endfunction

	// Stores one accepted point; a closing point queues its verdict.
	function automatic void predict_point(point_t p);
		verdict_t v;
		int k;
		if (pt_count < MAX_POINTS) begin
			pt_x[pt_count] = p.x;
			pt_y0[pt_count] = p.y0;
			pt_y1[pt_count] = p.y1;
			pt_count++;
		end else
			pt_dropped = 1;
		if (!p.last)
			return;
		fp = reg_modulus < 3 ? 3 : longint'(reg_modulus);
		k = reg_columns > MAX_TUPLE - 1 ? MAX_TUPLE - 1 : reg_columns;
		v = '{1'b0, 1'b0, 32'd0, STATUS_OK};
		if (pt_dropped)
			v.status = STATUS_MANY;
		else if (pt_count < k + 1)
			v.status = STATUS_FEW;
		else
			v = sweep_subsets(pt_count, k);
		verdict_q.push_back(v);
		pt_count = 0;
		pt_dropped = 0;
	endfunction

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 18);
	endfunction

	// Point driver: one transfer at a time, with a random gap after each.
	int     in_gap;
	point_t in_cur;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_point(in_cur);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (point_q.size() > 0) begin
					in_cur = point_q.pop_front();
					point_x <= in_cur.x;
					value_first <= in_cur.y0;
					value_second <= in_cur.y1;
					last_point <= in_cur.last;
					in_valid <= 1'b1;
					in_gap <= draw_wait();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: random stalls, and one long hold-off early on.
	int out_wait;
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait <= 0;
		end else if (out_valid && out_ready) begin
			results_seen++;
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result transfer with nothing expected: aligned=%0d status=%0d",
						aligned, status);
			end else begin
				want = verdict_q.pop_front();
				if (aligned !== want.aligned || has_gamma !== want.has_gamma ||
						gamma !== want.gamma || status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Result %0d: expected aligned=%0d has_gamma=%0d gamma=%0h ",
							"status=%0d, got aligned=%0d has_gamma=%0d gamma=%0h status=%0d"},
							results_seen, want.aligned, want.has_gamma, want.gamma,
							want.status, aligned, has_gamma, gamma, status);
				end
			end
			out_wait <= results_seen == 1 ? LONG_HOLD : draw_wait();
			out_ready <= 1'b0;
		end else if (out_wait > 0) begin
			out_wait <= out_wait - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MODULUS)
			reg_modulus = data;
		else
			reg_columns = data[2:0];
	endtask

	task automatic drain();
		while (point_q.size() > 0 || in_valid || verdict_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		return $urandom();
	endfunction

	// Builds one set of n points of the given kind under the current modulus, k columns.
	// Kinds: 0 aligned with gamma, 1 aligned without a second residual,
	// 2 fully degenerate, 3 noise.
	task automatic push_set(int n, int kind, int k);
		logic [31:0] ca[MAX_TUPLE];
		logic [31:0] cb[MAX_TUPLE];
		logic [31:0] g, x, xr, pa, pb, y1;
		point_t p;
		fp = reg_modulus < 3 ? 3 : longint'(reg_modulus);
		g = 32'(rand_word() % fp);
		for (int i = 0; i < MAX_TUPLE; i++) begin
			ca[i] = 32'(rand_word() % fp);
			cb[i] = 32'(rand_word() % fp);
		end
		for (int i = 0; i < n; i++) begin
			x = ($urandom_range(0, 3) == 0) ? rand_word() : 32'(rand_word() % fp);
			xr = 32'(x % fp);
			pa = 0;
			pb = 0;
			for (int j = k - 1; j >= 0; j--) begin
				pa = fadd(fmul(pa, xr), ca[j]);
				pb = fadd(fmul(pb, xr), cb[j]);
			end
			y1 = 32'(rand_word() % fp);
			p.x = x;
			p.last = (i == n - 1);
			case (kind)
				0: begin
					p.y1 = y1;
					p.y0 = fsub(pa, fmul(g, y1));
				end
				1: begin
					p.y0 = rand_word();
					p.y1 = pb;
				end
				2: begin
					p.y0 = pa;
					p.y1 = pb;
				end
				default: begin
					p.y0 = rand_word();
					p.y1 = rand_word();
				end
			endcase
			point_q.push_back(p);
		end
	endtask

	logic [31:0] phase_mod[8] = '{32'd4294967291, 32'd3, 32'd0, 32'd65521,
		32'd4294967295, 32'd2013265921, 32'd97, 32'd2};
	logic [2:0]  phase_col[8] = '{3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd5, 3'd6, 3'd1};

	initial begin
		int k, n, sent;
		mismatches = 0;
		results_seen = 0;
		pt_count = 0;
		pt_dropped = 0;
		watchdog = 0;
		no_idle = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes under the reset settings, too few and too many.
		fp = RESET_MODULUS;
		point_q.push_back('{32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0});
		point_q.push_back('{RESET_MODULUS - 1, 32'd0, 32'hFFFF_FFFF, 1'b1});
		point_q.push_back('{32'hFFFF_FFFF, 32'd5, 32'd7, 1'b1});
		for (int i = 0; i <= MAX_POINTS; i++)
			point_q.push_back('{rand_word(), rand_word(), rand_word(), i == MAX_POINTS});
		push_set(3, 0, 1);
		push_set(2, 1, 1);
		drain();

		// Random phases over several register settings.
		sent = 0;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_MODULUS, phase_mod[ph]);
			write_reg(CFG_COLUMNS, phase_col[ph]);
			no_idle = (ph % 3 == 2);
			k = phase_col[ph];
			for (int done = 0; done < 11; ) begin
				if ($urandom_range(0, 9) == 0)
					n = $urandom_range(1, k + 1);
				else if (k >= 4)
					n = k + 1 + $urandom_range(0, 1);
				else
					n = k + 1 + $urandom_range(0, 3);
				push_set(n, $urandom_range(0, 9) < 6 ? $urandom_range(0, 1)
					: $urandom_range(2, 3), k);
				done += n;
			end
			sent += 11;
			// The sender waits for every result before the next burst.
			drain();
		end

		// One overflowing set and a columns value of zero with full-width noise.
		write_reg(CFG_COLUMNS, 32'd0);
		write_reg(CFG_MODULUS, 32'hFFFF_FFFF);
		for (int i = 0; i < MAX_POINTS + 2; i++)
			point_q.push_back('{rand_word(), rand_word(), rand_word(), i == MAX_POINTS + 1});
		push_set(4, 3, 0);
		push_set(3, 0, 0);
		drain();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[filelist.f]
rtl/bva_pkg.sv
rtl/bva_ram.sv
rtl/bva_modmul.sv
rtl/bordered_vandermonde_alignment.sv
sim/tb_top.sv
